/* hw/rtl/spwc_pkg.sv */
// ----------------------------------------------------------------------------
// spwc_pkg: shared definitions for scan point window clustering
// Widths, register indexes, reset values, sequencer states and unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package spwc_pkg;

  // Default parameter values
  localparam int WINDOW_DEF       = 5;
  localparam int MAX_CLUSTERS_DEF = 1023;

  // Field widths
  localparam int COORD_W = 16;
  localparam int DIST_W  = 33;
  localparam int LABEL_W = 10;
  localparam int BACK_W  = 3;
  localparam int LABEL_MAX = 1023;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE_SQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_DIST_SQ = 1'd1;
  localparam logic [DIST_W-1:0] MIN_RANGE_SQ_RST = 33'd1;
  localparam logic [DIST_W-1:0] JOIN_DIST_SQ_RST = 33'd10000;

  // Per-request sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE_X,
    S_RANGE_Y,
    S_RANGE_CHK,
    S_DIST_X,
    S_DIST_Y,
    S_DIST_CMP,
    S_LABEL,
    S_DONE
  } spwc_state_e;

  // Squarer control
  typedef struct packed {
    logic en;     // load accumulator
    logic accum;  // add to previous value instead of replacing it
  } sq_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/spwc_sq_unit.sv */
// ----------------------------------------------------------------------------
// spwc_sq_unit: shared square-and-accumulate unit
// Computes (a - b)^2 and either loads or adds it to a 33-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module spwc_sq_unit (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire spwc_pkg::sq_ctrl_t                ctrl_i,
  input  wire logic signed [spwc_pkg::COORD_W-1:0] op_a_i,
  input  wire logic signed [spwc_pkg::COORD_W-1:0] op_b_i,
  output logic [spwc_pkg::DIST_W-1:0]            acc_o
);

  localparam int DiffW = spwc_pkg::COORD_W + 1;

  logic signed [DiffW-1:0]   diff;
  logic signed [2*DiffW-1:0] prod;
  logic [spwc_pkg::DIST_W-1:0] sq_val;
  logic [spwc_pkg::DIST_W-1:0] acc_d, acc_q;

  assign diff   = DiffW'(op_a_i) - DiffW'(op_b_i);
  assign prod   = diff * diff;
  // square of a 17-bit value is below 2^32, always non-negative
  assign sq_val = prod[spwc_pkg::DIST_W-1:0];

  // sums stay below 2^33 for any 16-bit coordinates
  assign acc_d = (ctrl_i.accum ? acc_q : '0) + sq_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* hw/rtl/spwc_window.sv */
// ----------------------------------------------------------------------------
// spwc_window: point history line
// Shift line of the last WINDOW points with labels; one read port, label write.
// ----------------------------------------------------------------------------
`default_nettype none

module spwc_window #(
  parameter int WINDOW = spwc_pkg::WINDOW_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      push_i,
  input  wire logic signed [spwc_pkg::COORD_W-1:0] push_x_i,
  input  wire logic signed [spwc_pkg::COORD_W-1:0] push_y_i,
  input  wire logic [spwc_pkg::LABEL_W-1:0]        push_lab_i,
  input  wire logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_idx_i,
  output logic signed [spwc_pkg::COORD_W-1:0]      rd_x_o,
  output logic signed [spwc_pkg::COORD_W-1:0]      rd_y_o,
  output logic [spwc_pkg::LABEL_W-1:0]             rd_lab_o,
  input  wire                                      lab_we_i,
  input  wire logic [spwc_pkg::LABEL_W-1:0]        lab_wdata_i
);

  logic signed [spwc_pkg::COORD_W-1:0] x_q   [WINDOW];
  logic signed [spwc_pkg::COORD_W-1:0] y_q   [WINDOW];
  logic [spwc_pkg::LABEL_W-1:0]        lab_q [WINDOW];

  // entry 0 is the most recent point; label write and push never coincide
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      x_q[0]   <= push_x_i;
      y_q[0]   <= push_y_i;
      lab_q[0] <= push_lab_i;
      for (int i = 1; i < WINDOW; i++) begin
        x_q[i]   <= x_q[i-1];
        y_q[i]   <= y_q[i-1];
        lab_q[i] <= lab_q[i-1];
      end
    end else if (lab_we_i) begin
      lab_q[rd_idx_i] <= lab_wdata_i;
    end
  end

  always_comb begin
    rd_x_o   = '0;
    rd_y_o   = '0;
    rd_lab_o = '0;
    if (32'(rd_idx_i) < WINDOW) begin
      rd_x_o   = x_q[rd_idx_i];
      rd_y_o   = y_q[rd_idx_i];
      rd_lab_o = lab_q[rd_idx_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/scan_point_window_clustering.sv */
// ----------------------------------------------------------------------------
// scan_point_window_clustering: nearest-neighbor clustering of scan points
// Labels each point with the cluster of its nearest recent neighbor when that lies within the join distance.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake               Payload
//  s_axis   in   tvalid/tready           tdata: pos_x, pos_y; tuser: scan_start
//  m_axis   out  tvalid/tready           tdata: label, seed_new, seed_back,
//                                               nearest_dist_sq, labels_full
//  cfg      in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
//  Sequence: a request runs a neighbor search over all WINDOW entries, or
//  skips it when the window is still filling or the point lies inside the
//  minimum range. The single squarer serves every step: two passes per
//  window entry (dx^2, then dy^2) plus one compare step.
//  Reset clears configuration to defaults, the fill count and label counter.
//  A finished result sits in the output register; the next request is taken
//  while it waits, and only the final write-back stalls on m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_point_window_clustering #(
  parameter int WINDOW       = spwc_pkg::WINDOW_DEF,
  parameter int MAX_CLUSTERS = spwc_pkg::MAX_CLUSTERS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // point requests
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // pos_x[15:0], pos_y[31:16]
  input  wire logic                          s_axis_tuser,  // scan_start
  // results
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // label[9:0], seed_new[10], seed_back[13:11], nearest_dist_sq[46:14], labels_full[47]
  output logic [47:0]                        m_axis_tdata,
  // configuration writes
  input  wire                                cfg_we_i,
  input  wire logic [spwc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [spwc_pkg::DIST_W-1:0]    cfg_data_i
);

  localparam int IdxW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FillW = $clog2(WINDOW + 1);
  localparam logic [spwc_pkg::LABEL_W-1:0] LabelCap =
    spwc_pkg::LABEL_W'((MAX_CLUSTERS > spwc_pkg::LABEL_MAX) ? spwc_pkg::LABEL_MAX
                                                            : MAX_CLUSTERS);

  // configuration registers
  logic [spwc_pkg::DIST_W-1:0] min_range_q, join_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= spwc_pkg::MIN_RANGE_SQ_RST;
      join_dist_q <= spwc_pkg::JOIN_DIST_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spwc_pkg::CFG_MIN_RANGE_SQ: min_range_q <= cfg_data_i;
        spwc_pkg::CFG_JOIN_DIST_SQ: join_dist_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and working registers
  spwc_pkg::spwc_state_e state_q, state_d;
  logic signed [spwc_pkg::COORD_W-1:0] x_q, y_q;
  logic [FillW-1:0]              fill_q, fill_d;
  logic [spwc_pkg::LABEL_W-1:0]  next_lab_q, next_lab_d;
  logic [IdxW-1:0]               j_q, j_d;
  logic [IdxW-1:0]               bj_q, bj_d;
  logic [spwc_pkg::DIST_W-1:0]   best_q, best_d;
  logic                          searched_q, searched_d;
  logic [spwc_pkg::LABEL_W-1:0]  lab_q, lab_d;
  logic                          seed_q, seed_d;
  logic                          full_q, full_d;

  // output register
  logic                          out_valid_q;
  logic [47:0]                   out_data_q;

  // shared squarer
  spwc_pkg::sq_ctrl_t                  sq_ctrl;
  logic signed [spwc_pkg::COORD_W-1:0] op_a, op_b;
  logic [spwc_pkg::DIST_W-1:0]         acc;

  // window access
  logic [IdxW-1:0]                     rd_idx;
  logic signed [spwc_pkg::COORD_W-1:0] rd_x, rd_y;
  logic [spwc_pkg::LABEL_W-1:0]        rd_lab;
  logic                                lab_we;
  logic [spwc_pkg::LABEL_W-1:0]        lab_wdata;
  logic                                push;

  logic       accept;
  logic       out_free;
  logic [4:0] back_w;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign back_w   = 5'(bj_q) + 5'd1;

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    next_lab_d   = next_lab_q;
    j_d          = j_q;
    bj_d         = bj_q;
    best_d       = best_q;
    searched_d   = searched_q;
    lab_d        = lab_q;
    seed_d       = seed_q;
    full_d       = full_q;
    sq_ctrl      = '0;
    op_a         = x_q;
    op_b         = '0;
    rd_idx       = j_q;
    lab_we       = 1'b0;
    lab_wdata    = '0;
    push         = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      spwc_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          // new scan: forget fill and label counter; the window refills
          if (s_axis_tuser) begin
            fill_d     = '0;
            next_lab_d = '0;
          end
          lab_d   = '0;
          seed_d  = 1'b0;
          full_d  = 1'b0;
          state_d = spwc_pkg::S_RANGE_X;
        end
      end
      spwc_pkg::S_RANGE_X: begin
        sq_ctrl.en = 1'b1;
        op_a       = x_q;
        state_d    = spwc_pkg::S_RANGE_Y;
      end
      spwc_pkg::S_RANGE_Y: begin
        sq_ctrl.en    = 1'b1;
        sq_ctrl.accum = 1'b1;
        op_a          = y_q;
        state_d       = spwc_pkg::S_RANGE_CHK;
      end
      spwc_pkg::S_RANGE_CHK: begin
        j_d = '0;
        if (fill_q == FillW'(WINDOW) && acc > min_range_q) begin
          searched_d = 1'b1;
          state_d    = spwc_pkg::S_DIST_X;
        end else begin
          searched_d = 1'b0;
          best_d     = '0;
          state_d    = spwc_pkg::S_DONE;
        end
      end
      spwc_pkg::S_DIST_X: begin
        sq_ctrl.en = 1'b1;
        op_a       = x_q;
        op_b       = rd_x;
        state_d    = spwc_pkg::S_DIST_Y;
      end
      spwc_pkg::S_DIST_Y: begin
        sq_ctrl.en    = 1'b1;
        sq_ctrl.accum = 1'b1;
        op_a          = y_q;
        op_b          = rd_y;
        state_d       = spwc_pkg::S_DIST_CMP;
      end
      spwc_pkg::S_DIST_CMP: begin
        // strict less-than keeps the more recent entry on a tie
        if (j_q == '0 || acc < best_q) begin
          best_d = acc;
          bj_d   = j_q;
        end
        if (j_q == IdxW'(WINDOW - 1)) begin
          state_d = spwc_pkg::S_LABEL;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = spwc_pkg::S_DIST_X;
        end
      end
      spwc_pkg::S_LABEL: begin
        rd_idx = bj_q;
        if (best_q < join_dist_q) begin
          if (rd_lab == '0) begin
            // unlabeled neighbor seeds a new cluster, or takes the cap
            if (next_lab_q < LabelCap) begin
              next_lab_d = next_lab_q + 1'b1;
              seed_d     = 1'b1;
            end else begin
              next_lab_d = LabelCap;
              full_d     = 1'b1;
            end
            lab_we    = 1'b1;
            lab_wdata = next_lab_d;
            lab_d     = next_lab_d;
          end else begin
            lab_d = rd_lab;
          end
        end
        state_d = spwc_pkg::S_DONE;
      end
      spwc_pkg::S_DONE: begin
        if (out_free) begin
          push = 1'b1;
          if (fill_q < FillW'(WINDOW)) begin
            fill_d = fill_q + 1'b1;
          end
          state_d = spwc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spwc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= spwc_pkg::S_IDLE;
      fill_q     <= '0;
      next_lab_q <= '0;
      j_q        <= '0;
      searched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      next_lab_q <= next_lab_d;
      j_q        <= j_d;
      searched_q <= searched_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= $signed(s_axis_tdata[15:0]);
      y_q <= $signed(s_axis_tdata[31:16]);
    end
    bj_q   <= bj_d;
    best_q <= best_d;
    lab_q  <= lab_d;
    seed_q <= seed_d;
    full_q <= full_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q[9:0]   <= lab_q;
      out_data_q[10]    <= seed_q;
      out_data_q[13:11] <= searched_q ? back_w[2:0] : 3'd0;
      out_data_q[46:14] <= best_q;
      out_data_q[47]    <= full_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  spwc_sq_unit u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  spwc_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i       (clk_i),
    .push_i      (push),
    .push_x_i    (x_q),
    .push_y_i    (y_q),
    .push_lab_i  (lab_q),
    .rd_idx_i    (rd_idx),
    .rd_x_o      (rd_x),
    .rd_y_o      (rd_y),
    .rd_lab_o    (rd_lab),
    .lab_we_i    (lab_we),
    .lab_wdata_i (lab_wdata)
  );

`ifndef ASSERT_OFF
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");

  a_seed_or_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[10] && m_axis_tdata[47]))
    else $error("seed_new and labels_full both set");

  a_label_needs_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9:0] != '0) |-> m_axis_tdata[13:11] != 3'd0 ||
      WINDOW % 8 == 0)
    else $error("label given without neighbor search");

  a_label_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_lab_q <= LabelCap)
    else $error("label counter beyond cap");

  a_push_frees_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free && state_q == spwc_pkg::S_DONE)
    else $error("result written over a pending one");
`endif

endmodule

`default_nettype wire
